FILE: design/ats_pkg.sv
// Package for the answer tone sequencer: register layout, shared types and the sine table.
package ats_pkg;

  // Sine table geometry (power of two)
  localparam int SINE_LEN = 256;
  localparam int PHASE_W  = $clog2(SINE_LEN);
  localparam int HALF_LEN = SINE_LEN / 2;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_SILENCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_SAMPLES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_SILENCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd5;

  // Register reset values
  localparam logic [7:0]  TONE_STEP_RST     = 8'd22;
  localparam logic [15:0] LEAD_SILENCE_RST  = 16'd51600;
  localparam logic [15:0] TONE_SAMPLES_RST  = 16'd10800;
  localparam logic [3:0]  SEGMENT_COUNT_RST = 4'd7;
  localparam logic [15:0] TRAIL_SILENCE_RST = 16'd1800;
  localparam logic [14:0] AMPLITUDE_RST     = 15'd16383;

  typedef struct packed {
    logic [7:0]  tone_step;
    logic [15:0] lead_silence_samples;
    logic [15:0] tone_samples;
    logic [3:0]  segment_count;
    logic [15:0] trail_silence_samples;
    logic [14:0] amplitude;
  } cfg_t;

  // One sample request from the sequencer to the tone stage
  typedef struct packed {
    logic               tone;
    logic [PHASE_W-1:0] phase;
    logic               active;
    logic               last;
  } tone_req_t;

  // Q1.15 sine entry: degree-13 Taylor series in Q30 on the folded quarter wave
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic signed [15:0] sine_q15(int unsigned k);
    logic [63:0] four;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    four = 64'(k) << 2;
    quad = four / 64'(SINE_LEN);
    rem  = four % 64'(SINE_LEN);
    if (quad[0]) rem = 64'(SINE_LEN) - rem;
    x  = (HALF_PI_Q30 * rem) / 64'(SINE_LEN);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return quad[1] ? -$signed(16'(v)) : $signed(16'(v));
  endfunction

  typedef logic signed [15:0] sine_rom_t [SINE_LEN];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int k = 0; k < SINE_LEN; k++) begin
      r[k] = sine_q15(k);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: design/ats_tick_if.sv
// Input channel: one tick transaction carrying the start request.
interface ats_tick_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink   (input valid, input start_req, output ready);
endinterface

FILE: design/ats_audio_if.sv
// Output channel: one audio sample transaction with its status flags.
interface ats_audio_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               active;
  logic               last;

  modport source (output valid, output sample, output active, output last, input ready);
  modport sink   (input valid, input sample, input active, input last, output ready);
endinterface

FILE: design/ats_seq.sv
// Sequencer: stage, segment, sample count and phase update for each tick.
module ats_seq (
  input  logic              clk,
  input  logic              rst,
  input  ats_pkg::cfg_t     cfg,
  ats_tick_if.sink          tick,
  output ats_pkg::tone_req_t req,
  output logic              req_vld,
  input  logic              req_rdy
);
  import ats_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LEAD  = 2'd1;
  localparam logic [1:0] ST_TONE  = 2'd2;
  localparam logic [1:0] ST_TRAIL = 2'd3;

  typedef struct packed {
    logic [1:0]         stage;
    logic [3:0]         seg_idx;
    logic [PHASE_W-1:0] phase;
  } seq_t;

  logic [1:0]         stage;
  logic [3:0]         seg_idx;
  logic [PHASE_W-1:0] phase;
  logic [15:0]        cnt;

  seq_t        cur;
  seq_t        nxt;
  logic [15:0] cnt_cur;
  logic [15:0] cnt_next;
  logic [16:0] cnt_inc;
  logic [15:0] stage_len;
  logic        act;
  logic        lst;
  logic        tick_fire;

  // Skip every stage that has nothing left to emit. Empty tone segments
  // each reverse the phase, so only the parity of their number matters.
  function automatic seq_t settle(seq_t st, cfg_t c);
    seq_t r;
    r = st;
    if (r.stage == ST_LEAD && c.lead_silence_samples == '0) begin
      r.stage   = ST_TONE;
      r.seg_idx = '0;
    end
    if (r.stage == ST_TONE) begin
      if (r.seg_idx >= c.segment_count) begin
        r.stage = ST_TRAIL;
      end else if (c.tone_samples == '0) begin
        if (c.segment_count[0] ^ r.seg_idx[0]) r.phase = r.phase ^ PHASE_W'(HALF_LEN);
        r.seg_idx = c.segment_count;
        r.stage   = ST_TRAIL;
      end
    end
    if (r.stage == ST_TRAIL && c.trail_silence_samples == '0) r.stage = ST_IDLE;
    return r;
  endfunction

  assign tick.ready = !req_vld || req_rdy;
  assign tick_fire  = tick.valid && tick.ready;

  // Next sequencer state for the tick at the input
  always_comb begin
    cur     = '{stage: stage, seg_idx: seg_idx, phase: phase};
    cnt_cur = cnt;
    if (tick.start_req) begin
      cur.stage   = ST_LEAD;
      cur.seg_idx = '0;
      cnt_cur     = '0;
      cur         = settle(cur, cfg);
    end

    case (cur.stage)
      ST_LEAD: stage_len = cfg.lead_silence_samples;
      ST_TONE: stage_len = cfg.tone_samples;
      default: stage_len = cfg.trail_silence_samples;
    endcase

    nxt      = cur;
    cnt_next = cnt_cur;
    cnt_inc  = {1'b0, cnt_cur} + 17'd1;
    act      = (cur.stage != ST_IDLE);
    lst      = 1'b0;

    if (act) begin
      if (cur.stage == ST_TONE) nxt.phase = cur.phase + PHASE_W'(cfg.tone_step);
      // a stage ends once its count reaches its length (or the count wraps)
      if (cnt_inc[16] || cnt_inc[15:0] >= stage_len) begin
        cnt_next = '0;
        case (cur.stage)
          ST_LEAD: begin
            nxt.stage   = ST_TONE;
            nxt.seg_idx = '0;
          end
          ST_TONE: begin
            nxt.phase   = nxt.phase ^ PHASE_W'(HALF_LEN);
            nxt.seg_idx = nxt.seg_idx + 4'd1;
          end
          default: nxt.stage = ST_IDLE;
        endcase
        nxt = settle(nxt, cfg);
        lst = (nxt.stage == ST_IDLE);
      end else begin
        cnt_next = cnt_inc[15:0];
      end
    end
  end

  // State and request register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage   <= ST_IDLE;
      seg_idx <= '0;
      phase   <= '0;
      cnt     <= '0;
      req_vld <= 1'b0;
    end else begin
      if (tick.ready) req_vld <= tick.valid;
      if (tick_fire) begin
        stage   <= nxt.stage;
        seg_idx <= nxt.seg_idx;
        phase   <= nxt.phase;
        cnt     <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      req.tone   <= (cur.stage == ST_TONE);
      req.phase  <= cur.phase;
      req.active <= act;
      req.last   <= lst;
    end
  end

endmodule

FILE: design/ats_tone.sv
// Tone stage: sine table read, amplitude scaling and the output register.
module ats_tone (
  input  logic               clk,
  input  logic               rst,
  input  logic [14:0]        amplitude,
  input  ats_pkg::tone_req_t req,
  input  logic               req_vld,
  output logic               req_rdy,
  ats_audio_if.source        audio
);
  import ats_pkg::*;

  logic               out_vld;
  logic signed [15:0] out_sample;
  logic               out_active;
  logic               out_last;

  logic signed [15:0] entry;
  logic               neg;
  logic [14:0]        mag;
  logic [29:0]        prod;
  logic [14:0]        scaled;
  logic signed [15:0] sample_next;

  assign req_rdy = !out_vld || audio.ready;

  // Scale the magnitude, truncating toward zero, then restore the sign; zero outside tone stages
  always_comb begin
    entry  = SINE_ROM[req.phase];
    neg    = entry[15];
    mag    = neg ? 15'(-entry) : entry[14:0];
    prod   = 30'(mag) * 30'(amplitude);
    scaled = prod[29:15];
    if (!req.tone) begin
      sample_next = '0;
    end else if (neg) begin
      sample_next = -$signed({1'b0, scaled});
    end else begin
      sample_next = $signed({1'b0, scaled});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (req_rdy) begin
      out_vld <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req_rdy && req_vld) begin
      out_sample <= sample_next;
      out_active <= req.active;
      out_last   <= req.last;
    end
  end

  assign audio.valid  = out_vld;
  assign audio.sample = out_sample;
  assign audio.active = out_active;
  assign audio.last   = out_last;

endmodule

FILE: design/answer_tone_sequencer.sv
// Answer tone sequencer top level: configuration registers, sequencer and tone stage.
//
// Each tick transaction yields exactly one sample transaction. A tick with
// start_req set restarts the sequence (lead silence, phase-reversed tone
// segments, trailing silence) and its own sample is the first one. The block
// sustains one tick per clock cycle while the sample side takes samples. A
// sample is registered in the sequencer request register and then in the
// tone stage output register. The rate is set by the sequencer state update
// (stage, segment, count and phase fed back); the sine table lookup and the
// amplitude multiply lie between the request and output registers. Sample
// backpressure stalls the tick side only once both pipeline registers are
// full. The tone phase is kept across segments and restarts and is cleared
// only by reset. Registers are written through cfg_we/cfg_idx/cfg_data and
// take effect at once; lengths and segment count are read live by a running
// sequence. Indexes beyond the amplitude register are ignored.
module answer_tone_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ats_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ats_pkg::CFG_DATA_W-1:0] cfg_data,
  ats_tick_if.sink                       tick,
  ats_audio_if.source                    audio
);
  import ats_pkg::*;

  cfg_t      cfg;
  tone_req_t req;
  logic      req_vld;
  logic      req_rdy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tone_step             <= TONE_STEP_RST;
      cfg.lead_silence_samples  <= LEAD_SILENCE_RST;
      cfg.tone_samples          <= TONE_SAMPLES_RST;
      cfg.segment_count         <= SEGMENT_COUNT_RST;
      cfg.trail_silence_samples <= TRAIL_SILENCE_RST;
      cfg.amplitude             <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TONE_STEP:     cfg.tone_step             <= cfg_data[7:0];
        REG_LEAD_SILENCE:  cfg.lead_silence_samples  <= cfg_data[15:0];
        REG_TONE_SAMPLES:  cfg.tone_samples          <= cfg_data[15:0];
        REG_SEGMENT_COUNT: cfg.segment_count         <= cfg_data[3:0];
        REG_TRAIL_SILENCE: cfg.trail_silence_samples <= cfg_data[15:0];
        REG_AMPLITUDE:     cfg.amplitude             <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  ats_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .tick    (tick),
    .req     (req),
    .req_vld (req_vld),
    .req_rdy (req_rdy)
  );

  ats_tone u_tone (
    .clk       (clk),
    .rst       (rst),
    .amplitude (cfg.amplitude),
    .req       (req),
    .req_vld   (req_vld),
    .req_rdy   (req_rdy),
    .audio     (audio)
  );

  // Final sample of a sequence always belongs to a running sequence
  a_last_active: assert property (@(posedge clk) disable iff (rst)
    audio.valid && audio.last |-> audio.active)
    else $error("last sample flagged while not active");

  // Idle ticks carry silence
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    audio.valid && !audio.active |-> audio.sample == 16'sd0)
    else $error("nonzero sample while idle");

  // Pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !audio.valid && !req_vld)
    else $error("pipeline not empty after reset");

endmodule

FILE: verif/answer_tone_sequencer_tb.sv
// Self-checking testbench for the answer tone sequencer: tick stimulus, sample prediction, checks.
module answer_tone_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ats_pkg::*;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_LEAD, SEQ_TONE, SEQ_TRAIL} seq_stage_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
    logic               last;
  } audio_t;

  // Indexes past the amplitude register; the block drops these writes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // Fixed-point sine generation constants (Q30)
  localparam longint unsigned FIX_ONE     = 64'd1073741824;
  localparam longint unsigned FIX_HALF_PI = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

  localparam int HOLD_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ats_tick_if  tick_ch ();
  ats_audio_if audio_ch ();

  answer_tone_sequencer uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .tick     (tick_ch),
    .audio    (audio_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: register copy, sequencer state and sine table
  cfg_t               regs;
  seq_stage_t         seq_stage;
  logic [PHASE_W-1:0] tone_phase;
  logic [3:0]         seg_idx;
  logic [15:0]        seq_count;
  int                 sine_lut [SINE_LEN];

  // Stimulus and scoreboard
  logic   start_queue [$];
  audio_t sample_exp_q [$];
  int     ticks_queued = 0;
  int     ticks_taken  = 0;
  int     seq_ticks    = 0;
  int     mismatches   = 0;
  bit     tick_fire    = 1'b0;
  bit     src_gaps     = 1'b0;
  bit     snk_gaps     = 1'b0;
  bit     hold_req     = 1'b0;
  int     src_gap_left = 0;
  int     snk_gap_left = 0;
  int     hold_left    = 0;

  // Q1.15 sine entry from a Taylor series on the folded quarter wave
  function automatic int sine_entry(int k);
    longint unsigned four, quad, rem, x, x2, t, s, v;
    four = 64'(k) * 4;
    quad = four / SINE_LEN;
    rem  = four % SINE_LEN;
    if (quad[0]) rem = SINE_LEN - rem;
    x  = (FIX_HALF_PI * rem) / SINE_LEN;
    x2 = (x * x) >> 30;
    t  = FIX_ONE;
    for (int i = 0; i < 6; i++) begin
      t = FIX_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
    end
    s = (x * t) >> 30;
    v = (s * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) v = 32767;
    return quad[1] ? -int'(v) : int'(v);
  endfunction

  function automatic void reset_predictor();
    for (int k = 0; k < SINE_LEN; k++) begin
      sine_lut[k] = sine_entry(k);
    end
    regs.tone_step             = TONE_STEP_RST;
    regs.lead_silence_samples  = LEAD_SILENCE_RST;
    regs.tone_samples          = TONE_SAMPLES_RST;
    regs.segment_count         = SEGMENT_COUNT_RST;
    regs.trail_silence_samples = TRAIL_SILENCE_RST;
    regs.amplitude             = AMPLITUDE_RST;
    seq_stage  = SEQ_IDLE;
    tone_phase = '0;
    seg_idx    = '0;
    seq_count  = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TONE_STEP:     regs.tone_step             = data[7:0];
      REG_LEAD_SILENCE:  regs.lead_silence_samples  = data;
      REG_TONE_SAMPLES:  regs.tone_samples          = data;
      REG_SEGMENT_COUNT: regs.segment_count         = data[3:0];
      REG_TRAIL_SILENCE: regs.trail_silence_samples = data;
      REG_AMPLITUDE:     regs.amplitude             = data[14:0];
      default: ;
    endcase
  endfunction

  // Half-table phase reversal at the end of a tone segment
  function automatic void reverse_phase();
    tone_phase = tone_phase + PHASE_W'(HALF_LEN);
    seg_idx    = seg_idx + 4'd1;
  endfunction

  // Walk past stages with nothing to emit
  function automatic void skip_empty_stages();
    for (int i = 0; i < 40; i++) begin
      if (seq_stage == SEQ_LEAD && regs.lead_silence_samples == 0) begin
        seq_stage = SEQ_TONE;
        seg_idx   = '0;
      end else if (seq_stage == SEQ_TONE && seg_idx >= regs.segment_count) begin
        seq_stage = SEQ_TRAIL;
      end else if (seq_stage == SEQ_TONE && regs.tone_samples == 0) begin
        reverse_phase();
      end else if (seq_stage == SEQ_TRAIL && regs.trail_silence_samples == 0) begin
        seq_stage = SEQ_IDLE;
      end else begin
        break;
      end
    end
  endfunction

  function automatic logic [15:0] stage_length();
    case (seq_stage)
      SEQ_LEAD: return regs.lead_silence_samples;
      SEQ_TONE: return regs.tone_samples;
      default:  return regs.trail_silence_samples;
    endcase
  endfunction

  // Expected sample for one tick; advances the predictor state
  function automatic audio_t next_audio(logic start);
    audio_t r;
    int     e;
    int     mag;
    int     prod;
    r = '0;
    if (start) begin
      seq_stage = SEQ_LEAD;
      seg_idx   = '0;
      seq_count = '0;
      skip_empty_stages();
    end
    if (seq_stage != SEQ_IDLE) begin
      r.active = 1'b1;
      if (seq_stage == SEQ_TONE) begin
        e    = sine_lut[tone_phase];
        mag  = (e < 0) ? -e : e;
        prod = (mag * int'(regs.amplitude)) >>> 15;
        r.sample   = 16'((e < 0) ? -prod : prod);
        tone_phase = tone_phase + regs.tone_step;
      end
      seq_count = seq_count + 16'd1;
      if (seq_count == 0 || seq_count >= stage_length()) begin
        seq_count = '0;
        case (seq_stage)
          SEQ_LEAD: begin
            seq_stage = SEQ_TONE;
            seg_idx   = '0;
          end
          SEQ_TONE: reverse_phase();
          default:  seq_stage = SEQ_IDLE;
        endcase
        skip_empty_stages();
        if (seq_stage == SEQ_IDLE) r.last = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    mismatches++;
    if (mismatches <= 50)
      $display("MISMATCH @%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
  endtask

  // Monitor: predict on each accepted tick, check each accepted sample
  always @(posedge clk) begin
    audio_t want;
    tick_fire = !rst && tick_ch.valid && tick_ch.ready;
    if (tick_fire) begin
      sample_exp_q.push_back(next_audio(tick_ch.start_req));
      ticks_taken++;
    end
    if (!rst && audio_ch.valid && audio_ch.ready) begin
      if (sample_exp_q.size() == 0) begin
        report_mismatch("sample with no tick pending", 0, audio_ch.sample);
      end else begin
        want = sample_exp_q.pop_front();
        if (audio_ch.sample !== want.sample)
          report_mismatch("sample", want.sample, audio_ch.sample);
        if (audio_ch.active !== want.active)
          report_mismatch("active", want.active, audio_ch.active);
        if (audio_ch.last !== want.last)
          report_mismatch("last", want.last, audio_ch.last);
      end
    end
  end

  // Tick driver: holds a transaction until taken, random gap bursts between
  always @(negedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else if (tick_ch.valid && !tick_fire) begin
      // waiting for the block to take the current tick
    end else if (src_gap_left > 0) begin
      src_gap_left--;
      tick_ch.valid <= 1'b0;
    end else if (src_gaps && $urandom_range(0, 7) == 0) begin
      src_gap_left = $urandom_range(1, 10) - 1;
      tick_ch.valid <= 1'b0;
    end else if (start_queue.size() > 0) begin
      tick_ch.valid     <= 1'b1;
      tick_ch.start_req <= start_queue.pop_front();
    end else begin
      tick_ch.valid <= 1'b0;
    end
  end

  // Sample receiver: long hold-off on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      audio_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      audio_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      audio_ch.ready <= 1'b0;
    end else if (snk_gap_left > 0) begin
      snk_gap_left--;
      audio_ch.ready <= 1'b0;
    end else if (snk_gaps && $urandom_range(0, 7) == 0) begin
      snk_gap_left = $urandom_range(1, 10) - 1;
      audio_ch.ready <= 1'b0;
    end else begin
      audio_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    apply_reg(idx, data);
  endtask

  // Program every register; unused upper data bits carry junk
  task automatic program_regs(logic [7:0] step, logic [15:0] lead, logic [15:0] tone,
                              logic [3:0] segs, logic [15:0] trail, logic [14:0] amp);
    write_reg(REG_TONE_STEP, {8'($urandom), step});
    write_reg(REG_LEAD_SILENCE, lead);
    write_reg(REG_TONE_SAMPLES, tone);
    write_reg(REG_SEGMENT_COUNT, {12'($urandom), segs});
    write_reg(REG_TRAIL_SILENCE, trail);
    write_reg(REG_AMPLITUDE, {1'($urandom), amp});
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_B : REG_SPARE_A, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_regs();
    logic [7:0]  step;
    logic [15:0] lead;
    logic [15:0] tone;
    logic [3:0]  segs;
    logic [15:0] trail;
    logic [14:0] amp;
    logic [15:0] wide;
    case ($urandom_range(0, 7))
      0:       step = 8'd0;
      1:       step = 8'd255;
      default: step = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       amp = 15'd0;
      1:       amp = 15'd32767;
      default: amp = 15'($urandom);
    endcase
    segs  = 4'($urandom_range(0, 15));
    tone  = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
    lead  = 16'($urandom_range(0, 6));
    trail = 16'($urandom_range(0, 6));
    // occasionally one very long stage, only ever cut short by a restart
    if ($urandom_range(0, 7) == 0) begin
      wide = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
      case ($urandom_range(0, 2))
        0:       lead  = wide;
        1:       tone  = wide;
        default: trail = wide;
      endcase
    end
    program_regs(step, lead, tone, segs, trail, amp);
  endtask

  task automatic push_tick(logic start);
    start_queue.push_back(start);
    ticks_queued++;
  endtask

  task automatic send_ticks(logic [31:0] starts, int count);
    @(posedge clk);
    for (int i = 0; i < count; i++) begin
      push_tick(starts[i]);
    end
  endtask

  function automatic int sequence_length();
    int tones;
    tones = (regs.segment_count != 0) ? int'(regs.segment_count) * int'(regs.tone_samples) : 0;
    return int'(regs.lead_silence_samples) + tones + int'(regs.trail_silence_samples);
  endfunction

  // Mostly complete sequences, some cut short by a restart, some idle ticks between
  task automatic queue_sequences(int min_ticks);
    int total;
    int len;
    int n;
    total = 0;
    repeat ($urandom_range(0, 2)) push_tick(1'b0);
    while (total < min_ticks) begin
      len = sequence_length();
      if (len > 300)
        n = $urandom_range(1, 40);
      else if (len > 1 && $urandom_range(0, 4) == 0)
        n = $urandom_range(1, len - 1);
      else
        n = (len == 0) ? 1 : len;
      push_tick(1'b1);
      repeat (n - 1) push_tick(1'b0);
      total += n;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) push_tick(1'b0);
    end
    seq_ticks += total;
  endtask

  // Wait until every tick is taken and every sample has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (ticks_taken != ticks_queued || sample_exp_q.size() != 0);
  endtask

  // Main sequence
  initial begin
    int phase_no;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    tick_ch.valid     = 1'b0;
    tick_ch.start_req = 1'b0;
    audio_ch.ready    = 1'b0;
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    src_gaps = 1'b1;
    snk_gaps = 1'b1;

    // Directed: reset settings, idle tick, start, lead silence
    send_ticks(32'b0010, 4);
    wait_drained();
    // Every stage empty: start tick stays idle, phase reversed fifteen times
    program_regs(8'd255, 16'd0, 16'd0, 4'd15, 16'd0, 15'd32767);
    send_ticks(32'b01, 2);
    wait_drained();
    // No tone segments: lead skipped straight to trailing silence
    program_regs(8'd9, 16'd0, 16'd1, 4'd0, 16'd2, 15'd1000);
    send_ticks(32'b001, 3);
    wait_drained();
    // Full scale, largest step, sequence runs out then idles
    program_regs(8'd255, 16'd1, 16'd2, 4'd2, 16'd0, 15'd32767);
    send_ticks(32'b0000001, 7);
    wait_drained();
    // Zero-length tone segments, zero amplitude and step
    program_regs(8'd0, 16'd2, 16'd0, 4'd3, 16'd1, 15'd0);
    send_ticks(32'b00001, 5);
    wait_drained();
    // Restart while running, longest trailing silence
    program_regs(8'd37, 16'd0, 16'd4, 4'd2, 16'd65535, 15'd20000);
    send_ticks(32'b001001, 6);
    wait_drained();

    // Random phases; settings change only once the block has drained
    phase_no = 0;
    while (seq_ticks < 1120) begin
      random_regs();
      @(posedge clk);
      src_gaps = $urandom_range(0, 3) != 0;
      snk_gaps = $urandom_range(0, 3) != 0;
      if (phase_no == 2) begin
        // receiver holds off while the ticks keep coming
        hold_req = 1'b1;
        queue_sequences(200);
      end else begin
        queue_sequences($urandom_range(40, 100));
      end
      wait_drained();
      phase_no++;
    end

    // Closing stretch at full rate
    random_regs();
    @(posedge clk);
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    queue_sequences(60);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("answer_tone_sequencer test passed");
    else
      $display("answer_tone_sequencer test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("answer_tone_sequencer test failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/ats_pkg.sv
design/ats_tick_if.sv
design/ats_audio_if.sv
design/ats_seq.sv
design/ats_tone.sv
design/answer_tone_sequencer.sv
verif/answer_tone_sequencer_tb.sv
